FILE: sv/lps_pkg.sv
// lps_pkg: shared types and constants of the led pattern sequencer
// mode codes, register indexes and field widths; no dependencies
package lps_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int LED_OUT_W = 8;
    localparam int MODE_W    = 2;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_mode MODE_FILL   = 2'd1;
    localparam t_mode MODE_MIRROR = 2'd2;
    localparam t_mode MODE_BLINK  = 2'd3;

    localparam t_cfg_idx REG_DEBOUNCE_TICKS = 2'd0;
    localparam t_cfg_idx REG_STEP_TICKS     = 2'd1;

    localparam t_cfg DEBOUNCE_TICKS_RST = 16'd50;
    localparam t_cfg STEP_TICKS_RST     = 16'd250;
    localparam t_cfg QUIET_MAX          = 16'hFFFF;

endpackage

FILE: sv/lps_debounce.sv
// lps_debounce: button debouncer and mode selector
// depends on lps_pkg; gives the mode selected after this tick's button level
module lps_debounce import lps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_level,
    input  t_cfg i_debounce_ticks,
    output t_mode o_mode
);

    logic  r_last, n_last;
    logic  r_stable, n_stable;
    t_cfg  r_quiet, n_quiet;
    t_mode r_sel, n_sel;

    always_comb begin
        n_last   = i_level;
        n_stable = r_stable;
        n_sel    = r_sel;
        if (i_level != r_last) begin
            n_quiet = '0;
        end else if (r_quiet != QUIET_MAX) begin
            n_quiet = r_quiet + t_cfg'(1);
        end else begin
            n_quiet = r_quiet;
        end
        if (n_quiet > i_debounce_ticks && i_level != r_stable) begin
            n_stable = i_level;
            if (!i_level) begin
                n_sel = (r_sel == MODE_BLINK) ? MODE_FILL : r_sel + t_mode'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b1;
            r_stable <= 1'b1;
            r_quiet  <= '0;
            r_sel    <= MODE_FILL;
        end else if (i_en) begin
            r_last   <= n_last;
            r_stable <= n_stable;
            r_quiet  <= n_quiet;
            r_sel    <= n_sel;
        end
    end

    assign o_mode = n_sel;

endmodule

FILE: sv/lps_pattern.sv
// lps_pattern: step timer and led pattern generator
// depends on lps_pkg; gives the led vector after this tick's update
module lps_pattern import lps_pkg::*; #(
    parameter int LED_COUNT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_mode                i_mode,
    input  t_cfg                 i_step_ticks,
    output logic [LED_OUT_W-1:0] o_led_bits
);

    localparam int N  = LED_COUNT;
    localparam int H  = (N - 1) / 2;
    localparam int SW = $clog2(2 * N);
    localparam int CW = SW + 1;
    localparam logic [CW-1:0] STEPS_FILL   = CW'(2 * N);
    localparam logic [CW-1:0] STEPS_MIRROR = CW'(N + H + 1);
    localparam logic [CW-1:0] STEPS_BLINK  = CW'(2);

    t_mode          r_play, n_play;
    logic [SW-1:0]  r_step, n_step;
    t_cfg           r_dwell, n_dwell;
    logic [N-1:0]   r_led, n_led;
    t_cfg           hold;
    logic           step_end;
    logic [CW-1:0]  step_inc;
    logic [CW-1:0]  steps;

    function automatic logic [N-1:0] apply_step(t_mode m, logic [SW-1:0] s,
                                                logic [N-1:0] cur);
        int           si;
        logic [N-1:0] res;
        si  = int'(s);
        res = cur;
        unique case (m)
            MODE_FILL: begin
                for (int i = 0; i < N; i++) begin
                    if (si < N && si == i) begin
                        res[i] = 1'b1;
                    end else if (si >= N && si == 2 * N - 1 - i) begin
                        res[i] = 1'b0;
                    end
                end
            end
            MODE_MIRROR: begin
                for (int i = 0; i < N; i++) begin
                    if (si < N) begin
                        if (si == i || si == N - 1 - i) begin
                            res[i] = 1'b1;
                        end
                    end else if (si <= N + H) begin
                        if (si == N + H - i || si == H + 1 + i) begin
                            res[i] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                res = (si == 0) ? '1 : '0;
            end
        endcase
        return res;
    endfunction

    always_comb begin
        hold     = (i_step_ticks == '0) ? t_cfg'(1) : i_step_ticks;
        step_end = ({1'b0, r_dwell} + 17'd1) >= {1'b0, hold};
        step_inc = {1'b0, r_step} + CW'(1);
        case (r_play)
            MODE_FILL:   steps = STEPS_FILL;
            MODE_MIRROR: steps = STEPS_MIRROR;
            default:     steps = STEPS_BLINK;
        endcase
        n_dwell = r_dwell + t_cfg'(1);
        n_play  = r_play;
        n_step  = r_step;
        n_led   = r_led;
        if (step_end) begin
            n_dwell = '0;
            if (i_mode != r_play) begin
                n_play = i_mode;
                n_step = '0;
            end else if (step_inc >= steps) begin
                n_step = '0;
            end else begin
                n_step = step_inc[SW-1:0];
            end
            n_led = apply_step(n_play, n_step, r_led);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play  <= MODE_FILL;
            r_step  <= '0;
            r_dwell <= '0;
            r_led   <= N'(1);
        end else if (i_en) begin
            r_play  <= n_play;
            r_step  <= n_step;
            r_dwell <= n_dwell;
            r_led   <= n_led;
        end
    end

    // only leds 0..7 are visible, missing ones read as off
    for (genvar b = 0; b < LED_OUT_W; b++) begin : g_out
        if (b < N) begin : g_led
            assign o_led_bits[b] = n_led[b];
        end else begin : g_off
            assign o_led_bits[b] = 1'b0;
        end
    end

endmodule

FILE: sv/led_pattern_sequencer_debounced.sv
// channel  | handshake                   | payload
// ---------+-----------------------------+------------------------------
// input    | i_in_valid / o_in_ready     | i_button_level
// result   | o_out_valid / i_out_ready   | o_led_bits, o_active_mode
// config   | i_cfg_we                    | i_cfg_idx, i_cfg_data
//
// one request per cycle unless stalled; each tick's result is registered on accept
// the result register parts the two sides: a new request is taken while the
// result is taken in the same cycle, and input stalls only while it is held
// synchronous active-low reset, no clearing pass; depends on lps_pkg,
// lps_debounce and lps_pattern
module led_pattern_sequencer_debounced import lps_pkg::*; #(
    parameter int LED_COUNT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_button_level,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [LED_OUT_W-1:0] o_led_bits,
    output logic [MODE_W-1:0]    o_active_mode,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg                 r_debounce_ticks;
    t_cfg                 r_step_ticks;
    logic                 r_out_valid;
    logic [LED_OUT_W-1:0] r_led_bits;
    t_mode                r_active_mode;
    logic                 accept;
    t_mode                mode;
    logic [LED_OUT_W-1:0] led_bits;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_TICKS_RST;
            r_step_ticks     <= STEP_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data;
                REG_STEP_TICKS:     r_step_ticks     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lps_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (accept),
        .i_level          (i_button_level),
        .i_debounce_ticks (r_debounce_ticks),
        .o_mode           (mode)
    );

    lps_pattern #(
        .LED_COUNT (LED_COUNT)
    ) u_pattern (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_mode       (mode),
        .i_step_ticks (r_step_ticks),
        .o_led_bits   (led_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_led_bits    <= led_bits;
            r_active_mode <= mode;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_led_bits    = r_led_bits;
    assign o_active_mode = r_active_mode;

endmodule

FILE: sv/lps_checker.sv
// lps_checker: port-level checks of the led pattern sequencer
// depends on lps_pkg; bound to led_pattern_sequencer_debounced
module lps_checker import lps_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [LED_OUT_W-1:0] o_led_bits,
    input logic [MODE_W-1:0]    o_active_mode
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_led_bits) && $stable(o_active_mode)))
        else $error("result changed while stalled");

    // no stall on the input side without a waiting result
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // every accepted request produces a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted request gave no result");

    // a shown mode is always one of the three patterns
    a_mode_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_active_mode != '0))
        else $error("result shows mode zero");

endmodule

bind led_pattern_sequencer_debounced lps_checker u_lps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_led_bits    (o_led_bits),
    .o_active_mode (o_active_mode)
);
